FILE: src/bezd_pkg.sv
package bezd_pkg;

  // Fixed datapath widths.
  localparam int unsigned E_W        = 48;   // band energy
  localparam int unsigned S_W        = 64;   // ring sum
  localparam int unsigned Q_W        = 112;  // ring sum of squares
  localparam int unsigned P_W        = 128;  // multiplier product
  localparam int unsigned A_W        = 64;   // multiplier operand a
  localparam int unsigned CH_W       = 16;   // multiplier chunk of operand b
  localparam int unsigned N_CHUNKS   = Q_W / CH_W;
  localparam int unsigned ROOT_W     = 64;
  localparam int unsigned REM_W      = 66;
  localparam int unsigned BIN_W      = 16;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned BAND_IDX_W = 5;
  localparam int unsigned BC_W       = 6;
  localparam int unsigned BPB_W      = 11;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned STEP_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BINS_PER_BAND = CFG_IDX_W'(1);

  localparam logic [BC_W-1:0]  BAND_COUNT_RST    = BC_W'(8);
  localparam logic [BPB_W-1:0] BINS_PER_BAND_RST = BPB_W'(64);

  localparam logic [STEP_W-1:0] SQRT_STEPS_M1 = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_STEPS_M1  = STEP_W'(SCORE_W - 1);

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_CLEAR = 5'd1;
  localparam op_t OP_LOAD  = 5'd2;
  localparam op_t OP_ACC   = 5'd3;
  localparam op_t OP_RD    = 5'd4;
  localparam op_t OP_SQ    = 5'd5;
  localparam op_t OP_QADD  = 5'd6;
  localparam op_t OP_HC    = 5'd7;
  localparam op_t OP_N     = 5'd8;
  localparam op_t OP_HQ    = 5'd9;
  localparam op_t OP_HQS   = 5'd10;
  localparam op_t OP_V     = 5'd11;
  localparam op_t OP_SQRT  = 5'd12;
  localparam op_t OP_DINIT = 5'd13;
  localparam op_t OP_DIV   = 5'd14;
  localparam op_t OP_EMIT  = 5'd15;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic close;
    logic idx_last;
    logic neg;
    logic vzero;
    logic nge;
    logic mul_done;
    logic out_free;
  } sts_t;

endpackage

FILE: src/bezd_if.sv
interface bezd_bin_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bezd_pkg::BIN_W-1:0]    bin_re;
  logic signed [bezd_pkg::BIN_W-1:0]    bin_im;
  modport source (output valid, bin_re, bin_im, input ready);
  modport sink   (input valid, bin_re, bin_im, output ready);
endinterface

interface bezd_score_if;
  logic                                valid;
  logic                                ready;
  logic [bezd_pkg::BAND_IDX_W-1:0]     band_index;
  logic [bezd_pkg::SCORE_W-1:0]        score;
  logic                                last_band;
  modport source (output valid, band_index, score, last_band, input ready);
  modport sink   (input valid, band_index, score, last_band, output ready);
endinterface

interface bezd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bezd_pkg::CFG_IDX_W-1:0]      index;
  logic [bezd_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bezd_ram.sv
module bezd_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bezd_mul.sv
module bezd_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bezd_pkg::A_W-1:0]   a_i,
  input  logic [bezd_pkg::Q_W-1:0]   b_i,
  output logic                       done_o,
  output logic [bezd_pkg::P_W-1:0]   prod_o
);

  // Most significant chunk of b first: acc = acc*2^16 + a*chunk.
  localparam logic [2:0] LAST_CHUNK = 3'(bezd_pkg::N_CHUNKS - 1);

  logic [bezd_pkg::A_W-1:0] a_q;
  logic [bezd_pkg::Q_W-1:0] b_q;
  logic [bezd_pkg::P_W-1:0] acc_q;
  logic [2:0]               cnt_q;
  logic                     busy_q;
  logic                     done_q;
  logic [bezd_pkg::A_W+bezd_pkg::CH_W-1:0] part;

  assign part = a_q * b_q[bezd_pkg::Q_W-1 -: bezd_pkg::CH_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == LAST_CHUNK) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[bezd_pkg::P_W-bezd_pkg::CH_W-1:0], {bezd_pkg::CH_W{1'b0}}}
               + bezd_pkg::P_W'(part);
      b_q   <= {b_q[bezd_pkg::Q_W-bezd_pkg::CH_W-1:0], {bezd_pkg::CH_W{1'b0}}};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: src/bezd_ctrl.sv
module bezd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bezd_pkg::sts_t       sts_i,
  output bezd_pkg::cmd_t       cmd_o
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_ACC   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_SQ    = 5'd4;
  localparam logic [4:0] S_SQW   = 5'd5;
  localparam logic [4:0] S_QADD  = 5'd6;
  localparam logic [4:0] S_HC    = 5'd7;
  localparam logic [4:0] S_HCW   = 5'd8;
  localparam logic [4:0] S_N     = 5'd9;
  localparam logic [4:0] S_HQ    = 5'd10;
  localparam logic [4:0] S_HQW   = 5'd11;
  localparam logic [4:0] S_HQS   = 5'd12;
  localparam logic [4:0] S_SSW   = 5'd13;
  localparam logic [4:0] S_V     = 5'd14;
  localparam logic [4:0] S_SQRT  = 5'd15;
  localparam logic [4:0] S_DINIT = 5'd16;
  localparam logic [4:0] S_DIV   = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  logic [4:0]                    state_q, state_d;
  logic [bezd_pkg::STEP_W-1:0]   step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o.op   = bezd_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = bezd_pkg::OP_CLEAR;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bezd_pkg::OP_LOAD;
          state_d  = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.op = bezd_pkg::OP_ACC;
        state_d  = sts_i.close ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd_o.op = bezd_pkg::OP_RD;
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = bezd_pkg::OP_SQ;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (sts_i.mul_done) state_d = S_QADD;
      end
      S_QADD: begin
        cmd_o.op = bezd_pkg::OP_QADD;
        state_d  = sts_i.idx_last ? S_HC : S_RD;
      end
      S_HC: begin
        cmd_o.op = bezd_pkg::OP_HC;
        state_d  = S_HCW;
      end
      S_HCW: begin
        if (sts_i.mul_done) state_d = S_N;
      end
      S_N: begin
        cmd_o.op = bezd_pkg::OP_N;
        state_d  = sts_i.neg ? S_EMIT : S_HQ;
      end
      S_HQ: begin
        cmd_o.op = bezd_pkg::OP_HQ;
        state_d  = S_HQW;
      end
      S_HQW: begin
        if (sts_i.mul_done) state_d = S_HQS;
      end
      S_HQS: begin
        cmd_o.op = bezd_pkg::OP_HQS;
        state_d  = S_SSW;
      end
      S_SSW: begin
        if (sts_i.mul_done) state_d = S_V;
      end
      S_V: begin
        cmd_o.op = bezd_pkg::OP_V;
        step_d   = bezd_pkg::SQRT_STEPS_M1;
        state_d  = sts_i.vzero ? S_EMIT : S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = bezd_pkg::OP_SQRT;
        step_d   = step_q - 1'b1;
        if (step_q == '0) state_d = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = bezd_pkg::OP_DINIT;
        step_d   = bezd_pkg::DIV_STEPS_M1;
        state_d  = sts_i.nge ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = bezd_pkg::OP_DIV;
        step_d   = step_q - 1'b1;
        if (step_q == '0) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = bezd_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: src/bezd_dp.sv
module bezd_dp #(
  parameter int unsigned HISTORY_DEPTH     = 64,
  parameter int unsigned MAX_BANDS         = 32,
  parameter int unsigned MAX_BINS_PER_BAND = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bezd_pkg::cmd_t                      cmd_i,
  output bezd_pkg::sts_t                      sts_o,
  input  logic signed [bezd_pkg::BIN_W-1:0]   bin_re_i,
  input  logic signed [bezd_pkg::BIN_W-1:0]   bin_im_i,
  input  logic [bezd_pkg::BC_W-1:0]           band_count_i,
  input  logic [bezd_pkg::BPB_W-1:0]          bins_per_band_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [bezd_pkg::BAND_IDX_W-1:0]     band_index_o,
  output logic [bezd_pkg::SCORE_W-1:0]        score_o,
  output logic                                last_band_o
);

  localparam int unsigned PW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned BNW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned CW  = (MAX_BINS_PER_BAND > 1) ? $clog2(MAX_BINS_PER_BAND) : 1;
  localparam int unsigned AW  = BNW + PW;
  localparam int unsigned RAM_DEPTH = 1 << AW;

  localparam logic [PW-1:0]  IDX_LAST  = PW'(HISTORY_DEPTH - 1);
  localparam logic [AW-1:0]  CLR_LAST  = AW'(RAM_DEPTH - 1);
  localparam logic [7:0]     MAXB      = 8'(MAX_BANDS);
  localparam logic [15:0]    MAXBIN    = 16'(MAX_BINS_PER_BAND);
  localparam logic [bezd_pkg::A_W-1:0] HMUL = bezd_pkg::A_W'(HISTORY_DEPTH);

  localparam int unsigned EW = bezd_pkg::E_W;

  logic signed [bezd_pkg::BIN_W-1:0] re_q, im_q;
  logic [EW-1:0]              acc_q, acc_n, cur_q;
  logic [CW-1:0]              bin_q;
  logic [BNW-1:0]             band_q;
  logic [PW-1:0]              wpos_q, idx_q;
  logic [AW-1:0]              clr_q;
  logic [bezd_pkg::S_W-1:0]   s_q, n_q;
  logic [bezd_pkg::Q_W-1:0]   q_q, hq_q, v;
  logic [bezd_pkg::P_W-1:0]   rad_q;
  logic [bezd_pkg::ROOT_W-1:0] root_q, drem_q, ddiff;
  logic [bezd_pkg::REM_W-1:0] srem_q;
  logic [bezd_pkg::SCORE_W-1:0] score_q;
  logic                       ovalid_q;
  logic [bezd_pkg::BAND_IDX_W-1:0] oband_q;
  logic [bezd_pkg::SCORE_W-1:0] oscore_q;
  logic                       olast_q;

  logic signed [31:0]         sq_re, sq_im;
  logic [32:0]                e;
  logic [EW:0]                sum;
  logic [15:0]                bpb_eff;
  logic [7:0]                 nb_eff;
  logic                       close, last;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr;
  logic [EW-1:0]              ram_wdata, ram_rdata;
  logic                       mul_start, mul_done;
  logic [bezd_pkg::A_W-1:0]   mul_a;
  logic [bezd_pkg::Q_W-1:0]   mul_b;
  logic [bezd_pkg::P_W-1:0]   prod;
  logic [bezd_pkg::REM_W+1:0] sq_tmp, sq_trial;
  logic                       sq_ge, dge;

  // Bin energy and saturating band accumulate.
  assign sq_re = re_q * re_q;
  assign sq_im = im_q * im_q;
  assign e     = 33'($unsigned(sq_re)) + 33'($unsigned(sq_im));
  assign sum   = {1'b0, acc_q} + (EW+1)'(e);
  assign acc_n = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];

  always_comb begin
    bpb_eff = 16'(bins_per_band_i);
    if (bpb_eff == 16'd0) bpb_eff = 16'd1;
    else if (bpb_eff > MAXBIN) bpb_eff = MAXBIN;
    nb_eff = 8'(band_count_i);
    if (nb_eff == 8'd0) nb_eff = 8'd1;
    else if (nb_eff > MAXB) nb_eff = MAXB;
  end

  assign close = (16'(bin_q) + 16'd1) >= bpb_eff;
  assign last  = (8'(band_q) + 8'd1) >= nb_eff;

  // History ring memory, addressed {band, slot}.
  assign ram_we    = (cmd_i.op == bezd_pkg::OP_CLEAR) || ((cmd_i.op == bezd_pkg::OP_ACC) && close);
  assign ram_waddr = (cmd_i.op == bezd_pkg::OP_CLEAR) ? clr_q : {band_q, wpos_q};
  assign ram_wdata = (cmd_i.op == bezd_pkg::OP_CLEAR) ? '0 : acc_n;
  assign ram_re    = (cmd_i.op == bezd_pkg::OP_RD);

  bezd_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i ({band_q, idx_q}),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier operand select.
  always_comb begin
    mul_start = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (cmd_i.op)
      bezd_pkg::OP_SQ: begin
        mul_a = bezd_pkg::A_W'(ram_rdata);
        mul_b = bezd_pkg::Q_W'(ram_rdata);
      end
      bezd_pkg::OP_HC: begin
        mul_a = bezd_pkg::A_W'(cur_q);
        mul_b = bezd_pkg::Q_W'(HMUL);
      end
      bezd_pkg::OP_HQ: begin
        mul_a = HMUL;
        mul_b = q_q;
      end
      bezd_pkg::OP_HQS: begin
        mul_a = s_q;
        mul_b = bezd_pkg::Q_W'(s_q);
      end
      default: mul_start = 1'b0;
    endcase
  end

  bezd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign v        = hq_q - prod[bezd_pkg::Q_W-1:0];
  assign sq_tmp   = {srem_q, rad_q[bezd_pkg::P_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_tmp >= sq_trial;
  assign ddiff    = root_q - drem_q;
  assign dge      = drem_q >= ddiff;

  assign sts_o.clr_done = (clr_q == CLR_LAST);
  assign sts_o.close    = close;
  assign sts_o.idx_last = (idx_q == IDX_LAST);
  assign sts_o.neg      = prod < bezd_pkg::P_W'(s_q);
  assign sts_o.vzero    = (v == '0);
  assign sts_o.nge      = n_q >= root_q;
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  // Architectural counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      bin_q    <= '0;
      band_q   <= '0;
      wpos_q   <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.op == bezd_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
      if (cmd_i.op == bezd_pkg::OP_ACC) begin
        if (close) begin
          acc_q <= '0;
          bin_q <= '0;
        end else begin
          acc_q <= acc_n;
          bin_q <= bin_q + 1'b1;
        end
      end
      if (cmd_i.op == bezd_pkg::OP_EMIT) begin
        ovalid_q <= 1'b1;
        if (last) begin
          band_q <= '0;
          wpos_q <= (wpos_q == IDX_LAST) ? '0 : wpos_q + 1'b1;
        end else begin
          band_q <= band_q + 1'b1;
        end
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Bin capture, score arithmetic and output register load.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bezd_pkg::OP_LOAD: begin
        re_q <= bin_re_i;
        im_q <= bin_im_i;
      end
      bezd_pkg::OP_ACC: begin
        cur_q <= acc_n;
        s_q   <= '0;
        q_q   <= '0;
        idx_q <= '0;
      end
      bezd_pkg::OP_SQ: s_q <= s_q + bezd_pkg::S_W'(ram_rdata);
      bezd_pkg::OP_QADD: begin
        q_q   <= q_q + prod[bezd_pkg::Q_W-1:0];
        idx_q <= idx_q + 1'b1;
      end
      bezd_pkg::OP_N: begin
        n_q     <= bezd_pkg::S_W'(prod - bezd_pkg::P_W'(s_q));
        score_q <= '0;
      end
      bezd_pkg::OP_HQS: hq_q <= prod[bezd_pkg::Q_W-1:0];
      bezd_pkg::OP_V: begin
        rad_q   <= {v, 16'h0000};
        root_q  <= '0;
        srem_q  <= '0;
        score_q <= '0;
      end
      bezd_pkg::OP_SQRT: begin
        rad_q <= {rad_q[bezd_pkg::P_W-3:0], 2'b00};
        if (sq_ge) begin
          srem_q <= bezd_pkg::REM_W'(sq_tmp - sq_trial);
          root_q <= {root_q[bezd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_q <= bezd_pkg::REM_W'(sq_tmp);
          root_q <= {root_q[bezd_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      bezd_pkg::OP_DINIT: begin
        drem_q  <= n_q;
        score_q <= (n_q >= root_q) ? {bezd_pkg::SCORE_W{1'b1}} : '0;
      end
      bezd_pkg::OP_DIV: begin
        score_q <= {score_q[bezd_pkg::SCORE_W-2:0], dge};
        drem_q  <= dge ? (drem_q - ddiff) : (drem_q + drem_q);
      end
      bezd_pkg::OP_EMIT: begin
        oband_q  <= bezd_pkg::BAND_IDX_W'(band_q);
        oscore_q <= score_q;
        olast_q  <= last;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = ovalid_q;
  assign band_index_o = oband_q;
  assign score_o      = oscore_q;
  assign last_band_o  = olast_q;

endmodule

FILE: src/band_energy_zscore_detector_core.sv
// Band energy z-score detector. FFT bins enter one transaction at a time;
// each bin's |X|^2 is added into a saturating 48-bit band energy, and after
// bins_per_band bins the band closes: its energy is written into that band's
// ring of HISTORY_DEPTH past energies and a score (c - mean)/std in unsigned
// Q8.8, saturating at 65535, leaves as one output transaction (0 when the
// energy is below the mean or the ring has no spread). The emit of a closing
// bin waits while the previous score is still held in the output register.
// The ring walk reads one entry per memory access and squares it on the
// shared 64x16 sequential multiplier (7 passes per multiply), followed by
// three more multiplies, a 64-step bit-serial square root and a 16-step
// divide; both are skipped when the score is 0, and the divide alone when
// the score saturates early. After reset a clearing pass zeroes the
// history memory, all 2^(clog2(MAX_BANDS)+clog2(HISTORY_DEPTH)) entries
// of it (2048 by default), during which no bin is accepted; configuration
// writes are taken at all times. Register 0 is band_count, register 1 is
// bins_per_band; write them only while the block is idle. A finished
// score waits in an output register while the next bin is accepted.
module band_energy_zscore_detector_core #(
  parameter int unsigned HISTORY_DEPTH     = 64,
  parameter int unsigned MAX_BANDS         = 32,
  parameter int unsigned MAX_BINS_PER_BAND = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bezd_bin_if.sink      bin_i,
  bezd_score_if.source  score_o,
  bezd_cfg_if.sink      cfg_i
);

  // Configuration registers.
  logic [bezd_pkg::BC_W-1:0]  band_count_q;
  logic [bezd_pkg::BPB_W-1:0] bins_per_band_q;

  bezd_pkg::cmd_t cmd;
  bezd_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q    <= bezd_pkg::BAND_COUNT_RST;
      bins_per_band_q <= bezd_pkg::BINS_PER_BAND_RST;
    end else if (cfg_i.valid) begin
      // unused indexes are dropped
      if (cfg_i.index == bezd_pkg::REG_BAND_COUNT) begin
        band_count_q <= cfg_i.data[bezd_pkg::BC_W-1:0];
      end else if (cfg_i.index == bezd_pkg::REG_BINS_PER_BAND) begin
        bins_per_band_q <= cfg_i.data;
      end
    end
  end

  // Sequencer: clearing pass, bin accept, ring walk, score math, emit.
  bezd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bin_i.valid),
    .in_ready_o (bin_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bezd_dp #(
    .HISTORY_DEPTH     (HISTORY_DEPTH),
    .MAX_BANDS         (MAX_BANDS),
    .MAX_BINS_PER_BAND (MAX_BINS_PER_BAND)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .bin_re_i        (bin_i.bin_re),
    .bin_im_i        (bin_i.bin_im),
    .band_count_i    (band_count_q),
    .bins_per_band_i (bins_per_band_q),
    .out_ready_i     (score_o.ready),
    .out_valid_o     (score_o.valid),
    .band_index_o    (score_o.band_index),
    .score_o         (score_o.score),
    .last_band_o     (score_o.last_band)
  );

  // No bin may slip in while the history memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == bezd_pkg::OP_CLEAR) |-> !bin_i.ready)
    else $error("bin ready during clearing pass");

  // Every accepted bin is accumulated on the next cycle.
  a_accept_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_i.valid && bin_i.ready) |=> (cmd.op == bezd_pkg::OP_ACC))
    else $error("accepted bin not accumulated");

  // A score only appears after the sequencer issued an emit.
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(score_o.valid) |-> $past(cmd.op == bezd_pkg::OP_EMIT))
    else $error("score valid without emit");

endmodule
